### hw/rtl/assert_macros.svh
// Assertion macros shared by the checker files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked property on clk_i, silenced while rst_ni is low.
`define EPS_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error(msg);

// Same-cycle implication.
`define EPS_ASSERT_IMPL(label, ante, cons, msg) \
  `EPS_ASSERT(label, (ante) |-> (cons), msg)

// Next-cycle implication.
`define EPS_ASSERT_NEXT(label, ante, cons, msg) \
  `EPS_ASSERT(label, (ante) |=> (cons), msg)

`endif

### hw/rtl/eps_pkg.sv
// Shared constants and types of the eutectic phase split evaluator.
package eps_pkg;

  localparam int FRAC_BITS  = 24;
  localparam int SLOPE_FRAC = 48;
  localparam int PS_SHIFT   = SLOPE_FRAC - FRAC_BITS;
  localparam int DW         = 32;   // external numeric field width
  localparam int PW         = 24;   // pressure width
  localparam int HW         = 27;   // latent heat register width
  localparam int VW         = 40;   // internal signed values
  localparam int QW         = 48;   // discriminant
  localparam int RW         = 36;   // square root result
  localparam int NW         = 60;   // divider dividend and quotient
  localparam int MW         = 37;   // divisor magnitude
  localparam int XW         = 64;   // result assembly
  localparam int LIM_EXP    = 60;
  localparam int IN_W       = 88;
  localparam int OUT_W      = 224;
  localparam int USER_W     = 4;

  typedef logic signed [VW-1:0] val_t;
  typedef logic signed [QW-1:0] disc_t;
  typedef logic signed [XW-1:0] ext_t;

  localparam val_t ONE_V = val_t'(64'sd1 <<< FRAC_BITS);
  localparam ext_t LIM_Q = 64'sd1 <<< LIM_EXP;

  typedef enum logic [2:0] {
    REG_INVALID   = 3'd0,
    REG_SOLID     = 3'd1,
    REG_TWO_SOLID = 3'd2,
    REG_EUTECTIC  = 3'd3,
    REG_SUPER     = 3'd4,
    REG_MELT      = 3'd5
  } region_e;

  localparam logic CFG_SLOPE = 1'b0;
  localparam logic CFG_HEAT  = 1'b1;

endpackage

### hw/rtl/eps_sqrt.sv
// Pipelined digit-by-digit integer square root, one result bit per stage.
module eps_sqrt #(
  parameter int RootW = 36
) (
  input  logic               clk_i,
  input  logic               en_i,
  input  logic [2*RootW-1:0] rad_i,
  output logic [RootW-1:0]   root_o
);

  logic [2*RootW-1:0] rad_q  [RootW-1];
  logic [RootW+1:0]   rem_q  [RootW-1];
  logic [RootW-1:0]   root_q [RootW];

  for (genvar k = 0; k < RootW; k++) begin : g_step
    logic [2*RootW-1:0] rad_in;
    logic [RootW+1:0]   rem_in;
    logic [RootW-1:0]   root_in;
    logic [RootW+1:0]   rem_sh;
    logic [RootW+1:0]   trial;
    logic               ge;

    if (k == 0) begin : g_first
      assign rad_in  = rad_i;
      assign rem_in  = '0;
      assign root_in = '0;
    end else begin : g_next
      assign rad_in  = rad_q[k-1];
      assign rem_in  = rem_q[k-1];
      assign root_in = root_q[k-1];
    end

    assign rem_sh = {rem_in[RootW-1:0], rad_in[2*RootW-1 -: 2]};
    assign trial  = {root_in, 2'b01};
    assign ge     = rem_sh >= trial;

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        root_q[k] <= {root_in[RootW-2:0], ge};
      end
    end

    if (k < RootW-1) begin : g_carry
      always_ff @(posedge clk_i) begin
        if (en_i) begin
          rad_q[k] <= rad_in << 2;
          rem_q[k] <= ge ? (rem_sh - trial) : rem_sh;
        end
      end
    end
  end

  assign root_o = root_q[RootW-1];

endmodule

### hw/rtl/eps_div.sv
// Pipelined restoring unsigned divider, one quotient bit per stage.
module eps_div #(
  parameter int NumW = 60,
  parameter int DenW = 37
) (
  input  logic            clk_i,
  input  logic            en_i,
  input  logic [NumW-1:0] num_i,
  input  logic [DenW-1:0] den_i,
  output logic [NumW-1:0] quo_o
);

  logic [NumW-1:0] num_q [NumW];
  logic [DenW-1:0] rem_q [NumW-1];
  logic [DenW-1:0] den_q [NumW-1];

  for (genvar k = 0; k < NumW; k++) begin : g_step
    logic [NumW-1:0] num_in;
    logic [DenW-1:0] rem_in;
    logic [DenW-1:0] den_in;
    logic [DenW:0]   trial;
    logic            ge;

    if (k == 0) begin : g_first
      assign num_in = num_i;
      assign rem_in = '0;
      assign den_in = den_i;
    end else begin : g_next
      assign num_in = num_q[k-1];
      assign rem_in = rem_q[k-1];
      assign den_in = den_q[k-1];
    end

    assign trial = {rem_in, num_in[NumW-1]};
    assign ge    = trial >= {1'b0, den_in};

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        num_q[k] <= {num_in[NumW-2:0], ge};
      end
    end

    if (k < NumW-1) begin : g_carry
      logic [DenW:0] diff;
      assign diff = trial - {1'b0, den_in};
      always_ff @(posedge clk_i) begin
        if (en_i) begin
          rem_q[k] <= ge ? diff[DenW-1:0] : trial[DenW-1:0];
          den_q[k] <= den_in;
        end
      end
    end
  end

  assign quo_o = num_q[NumW-1];

endmodule

### hw/rtl/eutectic_phase_split_eval.sv
// Eutectic phase split evaluator: streaming point classifier and phase solver.
//
// Usage:
//   Input stream (s_axis_*): one point per transaction, enthalpy, composition
//   and pressure. Output stream (m_axis_*): one result per point, in order,
//   temperature, three phase fractions, two temperature derivatives and the
//   pressure shift in tdata, region code and math fault flag in tuser.
//   Config port (cfg_*): index 0 writes the Clapeyron slope, index 1 the
//   latent heat; cfg_ready_o is always high. Write only while the pipeline
//   is empty.
// Pipeline:
//   Between input transaction and result lie four front stages, the 36-stage
//   square root, one stage to form the divider operands, the 60-stage dividers
//   and the output register. One point per cycle enters while the pipe advances.
// Stall:
//   All stages advance together. When a result waits in the output register
//   and the sink holds tready low, the whole pipe holds and s_axis_tready
//   drops; nothing is lost or repeated.
// Reset:
//   rst_ni clears all valid bits and loads the default slope (about 1e-6)
//   and latent heat (0.3).
module eutectic_phase_split_eval (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      s_axis_tvalid,
  output logic                      s_axis_tready,
  // enthalpy[31:0], composition[63:32], pressure[87:64]
  input  logic [eps_pkg::IN_W-1:0]  s_axis_tdata,
  output logic                      m_axis_tvalid,
  input  logic                      m_axis_tready,
  // melt_temperature[31:0], melt_frac[63:32], opx_frac[95:64],
  // olivine_frac[127:96], dtemp_dcomp[159:128], dtemp_denth[191:160],
  // pressure_shift[223:192]
  output logic [eps_pkg::OUT_W-1:0] m_axis_tdata,
  // phase_region[2:0], math_fault[3]
  output logic [eps_pkg::USER_W-1:0] m_axis_tuser,
  input  logic                      cfg_valid_i,
  output logic                      cfg_ready_o,
  input  logic                      cfg_index_i,
  input  logic [eps_pkg::DW-1:0]    cfg_data_i
);
  import eps_pkg::*;

  localparam int PRW = DW + PW;          // slope times pressure
  localparam int CCW = FRAC_BITS + 1;    // clamped composition
  localparam int SMW = 34;               // |enthalpy + melting point|
  localparam int TMW = DW + 1;           // melting point magnitude

  typedef struct packed {
    val_t               h;
    val_t               c;
    val_t               ps;
    val_t               tm;
    val_t               s;
    logic [CCW-1:0]     cc;
  } front_t;

  typedef struct packed {
    region_e region;
    val_t    h;
    val_t    c;
    val_t    ps;
    val_t    tm;
    val_t    s;
    logic    neg_disc;
  } sq_side_t;

  typedef struct packed {
    region_e region;
    val_t    h;
    val_t    c;
    val_t    ps;
    val_t    t;
    logic    neg1;
    logic    dneg1;
    logic    zero1;
    logic    zero_root;
    logic    neg3;
    logic    fault;
  } dv_side_t;

  function automatic val_t absv(input val_t v);
    return v[VW-1] ? -v : v;
  endfunction

  function automatic ext_t quot(input logic [NW-1:0] q, input logic neg,
                                input logic zero, input logic dneg);
    ext_t m;
    m = ext_t'(q);
    if (zero) return dneg ? -LIM_Q : LIM_Q;
    return neg ? -m : m;
  endfunction

  function automatic ext_t half(input ext_t v);
    return (v + ext_t'(v[XW-1])) >>> 1;
  endfunction

  function automatic logic [DW-1:0] sat32(input ext_t v);
    ext_t hi;
    hi = ext_t'(64'sd2147483647);
    if (v > hi) return DW'(hi);
    if (v < ~hi) return DW'(~hi);
    return DW'(v);
  endfunction

  // Configuration registers
  logic [DW-1:0] slope_q;
  logic [HW-1:0] heat_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slope_q <= 32'd281474977;
      heat_q  <= 27'd5033165;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_SLOPE: slope_q <= cfg_data_i;
        CFG_HEAT:  heat_q  <= cfg_data_i[HW-1:0];
        default:   ;
      endcase
    end
  end

  // Global advance: every stage moves unless a result is stuck at the output
  logic out_vld_q;
  logic adv;

  assign adv           = !out_vld_q || m_axis_tready;
  assign s_axis_tready = adv;

  // Stage 1: capture point, form slope * pressure
  logic                  v1_q;
  logic signed [DW-1:0]  h1_q, c1_q;
  logic [PRW-1:0]        prod1_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      h1_q    <= s_axis_tdata[DW-1:0];
      c1_q    <= s_axis_tdata[2*DW-1:DW];
      prod1_q <= PRW'(slope_q) * PRW'(s_axis_tdata[2*DW +: PW]);
    end
  end

  // Stage 2: pressure shift, melting point, clamp
  logic   v2_q;
  front_t f2_d, f2_q;

  always_comb begin
    f2_d.h  = val_t'(h1_q);
    f2_d.c  = val_t'(c1_q);
    f2_d.ps = val_t'(prod1_q[PS_SHIFT +: DW]);
    f2_d.tm = ONE_V + f2_d.ps;
    f2_d.s  = f2_d.h + f2_d.tm;
    if (f2_d.c[VW-1]) begin
      f2_d.cc = '0;
    end else if (f2_d.c > ONE_V) begin
      f2_d.cc = CCW'(ONE_V);
    end else begin
      f2_d.cc = CCW'(f2_d.c);
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) f2_q <= f2_d;
  end

  // Stage 3: products for boundary and discriminant
  logic                    v3_q;
  front_t                  f3_q;
  logic [2*SMW-1:0]        ssp3_q;
  logic [TMW+DW-1:0]       tmh3_q;
  logic [DW+HW-1:0]        clh3_q;
  logic [HW+CCW-1:0]       lbp3_q;
  logic                    hneg3_q, cneg3_q;
  logic [SMW-1:0]          smag;
  logic [DW-1:0]           hmag, cmag;

  assign smag = SMW'(absv(f2_q.s));
  assign hmag = DW'(absv(f2_q.h));
  assign cmag = DW'(absv(f2_q.c));

  always_ff @(posedge clk_i) begin
    if (adv) begin
      f3_q    <= f2_q;
      ssp3_q  <= (2*SMW)'(smag) * (2*SMW)'(smag);
      tmh3_q  <= (TMW+DW)'(f2_q.tm[TMW-1:0]) * (TMW+DW)'(hmag);
      clh3_q  <= (DW+HW)'(cmag) * (DW+HW)'(heat_q);
      lbp3_q  <= (HW+CCW)'(heat_q) * (HW+CCW)'(f2_q.cc);
      hneg3_q <= f2_q.h[VW-1];
      cneg3_q <= f2_q.c[VW-1];
    end
  end

  // Stage 4: classify and form the discriminant
  logic     v4_q;
  region_e  region4_d, region4_q;
  disc_t    disc4_d, disc4_q;
  front_t   f4_q;
  val_t     lb4, lc4;
  disc_t    ss4, tmh4, clh4;

  always_comb begin
    ss4  = disc_t'(ssp3_q[FRAC_BITS +: 44]);
    tmh4 = disc_t'(tmh3_q[FRAC_BITS +: 41]);
    clh4 = disc_t'(clh3_q[FRAC_BITS +: 35]);
    if (hneg3_q) tmh4 = -tmh4;
    if (cneg3_q) clh4 = -clh4;
    disc4_d = ss4 - ((tmh4 - clh4) <<< 2);
    lb4 = val_t'(lbp3_q[FRAC_BITS +: 28]) + f3_q.ps;
    lc4 = ONE_V + val_t'(heat_q) - val_t'(f3_q.cc) + f3_q.ps;
    if (f3_q.cc == '0 && f3_q.h <= f3_q.tm) begin
      region4_d = REG_SOLID;
    end else if (f3_q.h <= f3_q.ps) begin
      region4_d = REG_TWO_SOLID;
    end else if (f3_q.h <= lb4) begin
      region4_d = REG_EUTECTIC;
    end else if (f3_q.h <= lc4) begin
      region4_d = REG_SUPER;
    end else begin
      region4_d = REG_MELT;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      region4_q <= region4_d;
      disc4_q   <= disc4_d;
      f4_q      <= f3_q;
    end
  end

  // Square root of the discriminant, side data rides alongside
  logic [2*RW-1:0] rad;
  logic [RW-1:0]   root;
  sq_side_t        sq_in;
  sq_side_t        sq_q [RW];
  logic [RW-1:0]   sq_vld_q;

  assign rad = disc4_q[QW-1] ? '0 : ((2*RW)'(disc4_q) << FRAC_BITS);

  always_comb begin
    sq_in.region   = region4_q;
    sq_in.h        = f4_q.h;
    sq_in.c        = f4_q.c;
    sq_in.ps       = f4_q.ps;
    sq_in.tm       = f4_q.tm;
    sq_in.s        = f4_q.s;
    sq_in.neg_disc = disc4_q[QW-1];
  end

  eps_sqrt #(
    .RootW (RW)
  ) u_sqrt (
    .clk_i  (clk_i),
    .en_i   (adv),
    .rad_i  (rad),
    .root_o (root)
  );

  always_ff @(posedge clk_i) begin
    if (adv) begin
      sq_q[0] <= sq_in;
      for (int k = 1; k < RW; k++) sq_q[k] <= sq_q[k-1];
    end
  end

  // Stage 5: temperature and divider operands
  sq_side_t        sq5;
  val_t            diff5, t5, dv5, hp5, a5;
  logic            v5_q;
  dv_side_t        dv5_d, dv5_q;
  logic [NW-1:0]   num1_d, num1_q, num2_q, num3_d, num3_q;
  logic [MW-1:0]   den1_d, den1_q, denr_q;

  always_comb begin
    sq5   = sq_q[RW-1];
    diff5 = sq5.s - val_t'(root);
    t5    = (diff5 + val_t'(diff5[VW-1])) >>> 1;
    dv5   = sq5.tm - t5;
    hp5   = sq5.h - sq5.ps;
    a5    = sq5.h - (sq5.tm <<< 1);

    dv5_d.region    = sq5.region;
    dv5_d.h         = sq5.h;
    dv5_d.c         = sq5.c;
    dv5_d.ps        = sq5.ps;
    dv5_d.t         = t5;
    dv5_d.zero_root = (root == '0);
    dv5_d.neg3      = a5[VW-1];
    num3_d          = NW'(absv(a5)) << FRAC_BITS;

    if (sq5.region == REG_EUTECTIC) begin
      num1_d      = NW'(absv(hp5)) << FRAC_BITS;
      den1_d      = MW'(heat_q);
      dv5_d.neg1  = hp5[VW-1];
      dv5_d.dneg1 = hp5[VW-1];
      dv5_d.zero1 = (heat_q == '0);
    end else begin
      num1_d      = NW'(absv(sq5.c)) << FRAC_BITS;
      den1_d      = MW'(absv(dv5));
      dv5_d.neg1  = sq5.c[VW-1] ^ dv5[VW-1];
      dv5_d.dneg1 = sq5.c[VW-1];
      dv5_d.zero1 = (dv5 == '0);
    end

    case (sq5.region)
      REG_EUTECTIC: dv5_d.fault = dv5_d.zero1;
      REG_SUPER:    dv5_d.fault = sq5.neg_disc || dv5_d.zero_root || dv5_d.zero1;
      default:      dv5_d.fault = 1'b0;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      dv5_q  <= dv5_d;
      num1_q <= num1_d;
      den1_q <= den1_d;
      num2_q <= NW'(heat_q) << FRAC_BITS;
      num3_q <= num3_d;
      denr_q <= MW'(root);
    end
  end

  // Three dividers: melt fraction, composition derivative, enthalpy derivative
  logic [NW-1:0] quo1, quo2, quo3;

  eps_div #(.NumW (NW), .DenW (MW)) u_div_melt (
    .clk_i (clk_i), .en_i (adv), .num_i (num1_q), .den_i (den1_q), .quo_o (quo1)
  );

  eps_div #(.NumW (NW), .DenW (MW)) u_div_dcomp (
    .clk_i (clk_i), .en_i (adv), .num_i (num2_q), .den_i (denr_q), .quo_o (quo2)
  );

  eps_div #(.NumW (NW), .DenW (MW)) u_div_denth (
    .clk_i (clk_i), .en_i (adv), .num_i (num3_q), .den_i (denr_q), .quo_o (quo3)
  );

  dv_side_t      dv_q [NW];
  logic [NW-1:0] dv_vld_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      dv_q[0] <= dv5_q;
      for (int k = 1; k < NW; k++) dv_q[k] <= dv_q[k-1];
    end
  end

  // Stage 6: assemble and saturate the result
  dv_side_t          sd6;
  ext_t              q1v, q2v, q3v, one_x;
  ext_t              t6, melt6, opx6, olv6, dc6, dh6;
  logic [OUT_W-1:0]  data6;
  logic [USER_W-1:0] user6;
  logic [OUT_W-1:0]  out_data_q;
  logic [USER_W-1:0] out_user_q;

  always_comb begin
    sd6   = dv_q[NW-1];
    one_x = ext_t'(ONE_V);
    q1v   = quot(quo1, sd6.neg1, sd6.zero1, sd6.dneg1);
    q2v   = quot(quo2, 1'b0, sd6.zero_root, 1'b0);
    q3v   = quot(quo3, sd6.neg3, sd6.zero_root, sd6.neg3);
    t6    = '0;
    melt6 = '0;
    opx6  = '0;
    olv6  = '0;
    dc6   = '0;
    dh6   = '0;
    case (sd6.region)
      REG_SOLID: begin
        t6   = ext_t'(sd6.h);
        olv6 = one_x;
        dh6  = one_x;
      end
      REG_TWO_SOLID: begin
        t6   = ext_t'(sd6.h);
        opx6 = ext_t'(sd6.c);
        olv6 = one_x - ext_t'(sd6.c);
        dh6  = one_x;
      end
      REG_EUTECTIC: begin
        melt6 = q1v;
        opx6  = ext_t'(sd6.c) - q1v;
        olv6  = one_x - q1v - opx6;
        t6    = ext_t'(sd6.ps);
      end
      REG_SUPER: begin
        t6    = ext_t'(sd6.t);
        melt6 = q1v;
        olv6  = one_x - q1v;
        dc6   = -q2v;
        dh6   = half(one_x + q3v);
      end
      REG_MELT: begin
        t6    = ext_t'(sd6.h) - ext_t'(heat_q);
        melt6 = one_x;
        dh6   = one_x;
      end
      default: ;
    endcase
    data6 = {sat32(ext_t'(sd6.ps)), sat32(dh6), sat32(dc6), sat32(olv6),
             sat32(opx6), sat32(melt6), sat32(t6)};
    user6 = {sd6.fault, sd6.region};
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      out_data_q <= data6;
      out_user_q <= user6;
    end
  end

  // Valid bits travel with the data
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q      <= 1'b0;
      v2_q      <= 1'b0;
      v3_q      <= 1'b0;
      v4_q      <= 1'b0;
      sq_vld_q  <= '0;
      v5_q      <= 1'b0;
      dv_vld_q  <= '0;
      out_vld_q <= 1'b0;
    end else if (adv) begin
      v1_q      <= s_axis_tvalid;
      v2_q      <= v1_q;
      v3_q      <= v2_q;
      v4_q      <= v3_q;
      sq_vld_q  <= {sq_vld_q[RW-2:0], v4_q};
      v5_q      <= sq_vld_q[RW-1];
      dv_vld_q  <= {dv_vld_q[NW-2:0], v5_q};
      out_vld_q <= dv_vld_q[NW-1];
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tuser  = out_user_q;

endmodule

### hw/rtl/eps_check.sv
// Port-level checker for the eutectic phase split evaluator, bound to the top.
`include "assert_macros.svh"

module eps_check (
  input logic                       clk_i,
  input logic                       rst_ni,
  input logic                       m_axis_tvalid,
  input logic                       m_axis_tready,
  input logic [eps_pkg::OUT_W-1:0]  m_axis_tdata,
  input logic [eps_pkg::USER_W-1:0] m_axis_tuser
);
  import eps_pkg::*;

  localparam logic [DW-1:0] ONE_D = DW'(ONE_V);

  // Hold a stalled result unchanged.
  `EPS_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser), "stalled result changed")

  // Raise the fault flag only in the eutectic or super-eutectic region.
  `EPS_ASSERT_IMPL(a_fault_region, m_axis_tvalid && m_axis_tuser[3], m_axis_tuser[2:0] == REG_EUTECTIC || m_axis_tuser[2:0] == REG_SUPER, "fault outside regions 3 and 4")

  // Unit enthalpy derivative in the single-phase and two-solid regions.
  `EPS_ASSERT_IMPL(a_unit_denth, m_axis_tvalid && (m_axis_tuser[2:0] == REG_SOLID || m_axis_tuser[2:0] == REG_TWO_SOLID || m_axis_tuser[2:0] == REG_MELT), m_axis_tdata[191:160] == ONE_D, "dtemp_denth not one")

  // Eutectic temperature equals the pressure shift.
  `EPS_ASSERT_IMPL(a_eutectic_temp, m_axis_tvalid && m_axis_tuser[2:0] == REG_EUTECTIC, m_axis_tdata[31:0] == m_axis_tdata[223:192], "eutectic temperature off the shifted line")

endmodule

bind eutectic_phase_split_eval eps_check u_eps_check (.*);

### tb/eutectic_phase_split_eval_tb.sv
// Self-checking testbench of the eutectic phase split evaluator.
`timescale 1ns / 1ps

module eutectic_phase_split_eval_tb;
  import eps_pkg::*;

  localparam longint ONE_Q   = 64'sd1 <<< 24;
  localparam longint LIM_S   = 64'sd1 <<< 60;
  localparam int     DRAIN_CYC = 120;   // longer than the pipe takes to drain

  typedef struct packed {
    logic [31:0] h;
    logic [31:0] c;
    logic [23:0] p;
  } point_t;

  // First member lands in the top bits: temp sits at [31:0] like tdata.
  typedef struct packed {
    logic        fault;
    region_e     region;
    logic [31:0] ps, dh, dc, olv, opx, melt, temp;
  } phase_result_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [IN_W-1:0] s_axis_tdata = '0;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [OUT_W-1:0] m_axis_tdata;
  logic [USER_W-1:0] m_axis_tuser;
  logic cfg_valid_i = 1'b0;
  logic cfg_ready_o;
  logic cfg_index_i = CFG_SLOPE;
  logic [DW-1:0] cfg_data_i = '0;

  eutectic_phase_split_eval u_top (
    .clk_i, .rst_ni,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tuser,
    .cfg_valid_i, .cfg_ready_o, .cfg_index_i, .cfg_data_i
  );

  // Predictor copy of the two registers, reset values first.
  logic [31:0] slope_cfg = 32'd281474977;
  logic [26:0] heat_cfg  = 27'd5033165;

  point_t        point_q[$];        // points waiting to be sent
  phase_result_t phase_exp_q[$];    // predicted results, oldest first
  bit            math_flag;
  bit            feed_hold = 1'b0;
  bit            steady = 1'b0;     // no idling on either side while set
  int            mismatch_cnt = 0;
  int            point_cnt = 0;
  int            result_cnt = 0;
  int            region_seen[6];
  int            fault_cnt = 0;

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #5ms;
    $display("timeout with %0d results still pending", phase_exp_q.size());
    $display("eutectic_phase_split_eval_tb NOT OK");
    $finish;
  end

  // ---------------------------------------------------------------- predictor
  function automatic longint clamp60(longint v);
    if (v > LIM_S) return LIM_S;
    if (v < -LIM_S) return -LIM_S;
    return v;
  endfunction

  function automatic longint unsigned mag60(longint v);
    longint w;
    w = clamp60(v);
    return (w < 0) ? -w : w;
  endfunction

  function automatic longint sat_mag(logic [127:0] q, bit neg);
    longint m;
    m = (q > 128'(LIM_S)) ? LIM_S : longint'(q[63:0]);
    return neg ? -m : m;
  endfunction

  // Fixed-point product, truncated toward zero.
  function automatic longint fx_mul(longint a, longint b);
    logic [127:0] pa, pb, prod;
    pa = mag60(a);
    pb = mag60(b);
    prod = (pa * pb) >> 24;
    return sat_mag(prod, (a < 0) != (b < 0));
  endfunction

  // Fixed-point quotient; a zero divisor raises math_flag and saturates.
  function automatic longint fx_div(longint a, longint b);
    logic [127:0] num, den;
    den = mag60(b);
    if (den == 0) begin
      math_flag = 1'b1;
      return (a < 0) ? -LIM_S : LIM_S;
    end
    num = 128'(mag60(a)) << 24;
    return sat_mag(num / den, (a < 0) != (b < 0));
  endfunction

  function automatic longint fx_sqrt(longint v);
    logic [127:0] x, c2;
    longint unsigned r, c;
    if (v <= 0) return 0;
    x = 128'(v) << 24;
    r = 0;
    for (int k = 62; k >= 0; k--) begin
      c = r | (64'd1 << k);
      c2 = 128'(c) * 128'(c);
      if (c2 <= x) r = c;
    end
    return longint'(r);
  endfunction

  function automatic logic [31:0] sat32(longint v);
    if (v > 64'sd2147483647) return 32'h7fffffff;
    if (v < -64'sd2147483648) return 32'h80000000;
    return v[31:0];
  endfunction

  function automatic longint shift_of(logic [23:0] p);
    return longint'((64'(slope_cfg) * 64'(p)) >> 24);
  endfunction

  // Place one point in the phase diagram and solve that region.
  function automatic phase_result_t split_point(point_t pt);
    longint h, c, lh, ps, tm, cc, lb, lc;
    longint t, melt, opx, olv, dc, dh, s, disc, root;
    region_e region;
    phase_result_t res;
    h = longint'(signed'(pt.h));
    c = longint'(signed'(pt.c));
    lh = longint'(heat_cfg);
    ps = shift_of(pt.p);
    tm = ONE_Q + ps;
    cc = (c < 0) ? 0 : ((c > ONE_Q) ? ONE_Q : c);
    lb = fx_mul(lh, cc) + ps;
    lc = ONE_Q + lh - cc + ps;
    t = 0; melt = 0; opx = 0; olv = 0; dc = 0; dh = 0;
    math_flag = 1'b0;
    if (cc == 0 && h <= ONE_Q + ps) region = REG_SOLID;
    else if (h <= ps) region = REG_TWO_SOLID;
    else if (h <= lb) region = REG_EUTECTIC;
    else if (h <= lc) region = REG_SUPER;
    else region = REG_MELT;
    case (region)
      REG_SOLID: begin
        t = h; olv = ONE_Q; dh = ONE_Q;
      end
      REG_TWO_SOLID: begin
        t = h; opx = c; olv = ONE_Q - c; dh = ONE_Q;
      end
      REG_EUTECTIC: begin
        melt = fx_div(h - ps, lh);
        opx = clamp60(c - melt);
        olv = clamp60(ONE_Q - melt - opx);
        t = ps;
      end
      REG_SUPER: begin
        s = clamp60(h + tm);
        disc = clamp60(fx_mul(s, s) - 4 * clamp60(fx_mul(tm, h) - fx_mul(c, lh)));
        // negative discriminant: flag it and solve with a zero root
        if (disc < 0) begin
          math_flag = 1'b1;
          root = 0;
        end else begin
          root = fx_sqrt(disc);
        end
        t = clamp60(s - root) / 2;
        melt = fx_div(c, clamp60(tm - t));
        olv = clamp60(ONE_Q - melt);
        dc = -fx_div(lh, root);
        dh = clamp60(ONE_Q + fx_div(clamp60(h - 2 * tm), root)) / 2;
      end
      default: begin
        t = h - lh; melt = ONE_Q; dh = ONE_Q;
      end
    endcase
    res.fault = math_flag;
    res.region = region;
    res.temp = sat32(t);
    res.melt = sat32(melt);
    res.opx = sat32(opx);
    res.olv = sat32(olv);
    res.dc = sat32(dc);
    res.dh = sat32(dh);
    res.ps = sat32(ps);
    return res;
  endfunction

  // ---------------------------------------------------------------- idling
  // Mostly back to back or short gaps, now and then a long one.
  function automatic int pick_gap();
    int r;
    if (steady) return 0;
    r = $urandom_range(99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(12, 60);
  endfunction

  // ---------------------------------------------------------------- driver
  int     feed_gap = 0;
  point_t cur_pt;

  always @(posedge clk_i) begin : feed
    logic fire;
    fire = s_axis_tvalid && s_axis_tready;
    if (rst_ni) begin
      if (fire) begin
        phase_exp_q.push_back(split_point(cur_pt));
        point_cnt++;
      end
      // Hold the current transaction until it is taken; then advance.
      if (!s_axis_tvalid || fire) begin
        if (feed_gap > 0) begin
          feed_gap--;
          s_axis_tvalid <= 1'b0;
        end else if (point_q.size() > 0 && !feed_hold) begin
          cur_pt = point_q.pop_front();
          s_axis_tdata <= {cur_pt.p, cur_pt.c, cur_pt.h};
          s_axis_tvalid <= 1'b1;
          feed_gap = pick_gap();
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------- monitor
  int    sink_stall = 0;
  string field_name[7] = '{"melt_temperature", "melt_frac", "opx_frac", "olivine_frac",
                           "dtemp_dcomp", "dtemp_denth", "pressure_shift"};

  task automatic report_mismatch(string what);
    mismatch_cnt++;
    if (mismatch_cnt <= 40) $display("[%0t] mismatch: %s", $realtime, what);
  endtask

  always @(posedge clk_i) begin : sink
    phase_result_t want;
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) begin
        result_cnt++;
        if (phase_exp_q.size() == 0) begin
          report_mismatch("result arrived with nothing expected");
        end else begin
          want = phase_exp_q.pop_front();
          if (m_axis_tuser[2:0] !== want.region)
            report_mismatch($sformatf("phase_region got %0d want %0d",
                                      m_axis_tuser[2:0], want.region));
          if (m_axis_tuser[3] !== want.fault)
            report_mismatch($sformatf("math_fault got %b want %b",
                                      m_axis_tuser[3], want.fault));
          for (int k = 0; k < 7; k++) begin
            if (m_axis_tdata[32*k +: 32] !== want[32*k +: 32])
              report_mismatch($sformatf("%s got %h want %h (region %0d)", field_name[k],
                                        m_axis_tdata[32*k +: 32], want[32*k +: 32],
                                        want.region));
          end
          region_seen[want.region]++;
          if (want.fault) fault_cnt++;
        end
      end
      // Drop tready for a random stall, then raise it again.
      if (sink_stall > 0) begin
        sink_stall--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
        sink_stall = pick_gap();
      end
    end
  end

  // ---------------------------------------------------------------- stimulus
  // Wait until the pipe is empty, then let it settle before touching a register.
  task automatic settle();
    do begin
      while (point_q.size() > 0 || s_axis_tvalid || phase_exp_q.size() > 0)
        @(posedge clk_i);
      repeat (DRAIN_CYC) @(posedge clk_i);
    end while (point_q.size() > 0 || s_axis_tvalid || phase_exp_q.size() > 0);
  endtask

  task automatic write_reg(logic idx, logic [31:0] value);
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    if (idx == CFG_SLOPE) slope_cfg = value;
    else heat_cfg = value[26:0];
    cfg_valid_i <= 1'b0;
  endtask

  function automatic point_t mk(longint h, longint c, longint p);
    point_t pt;
    pt.h = h[31:0];
    pt.c = c[31:0];
    pt.p = p[23:0];
    return pt;
  endfunction

  // Mostly points near the region boundaries, some fully random.
  function automatic point_t random_point();
    point_t pt;
    longint c, ps, off, span;
    int r;
    r = $urandom_range(99);
    if (r < 15) begin
      pt.h = $urandom;
      pt.c = $urandom;
      pt.p = 24'($urandom);
      return pt;
    end
    pt.p = (r < 65) ? 24'($urandom_range(0, 4095)) : 24'($urandom);
    case ($urandom_range(9))
      0: c = -longint'($urandom_range(1, 32'h7fffffff));
      1: c = ONE_Q + longint'($urandom_range(1, 32'h7effffff));
      2: c = 0;
      3: c = ONE_Q;
      default: c = longint'($urandom_range(0, 32'h0100_0000));
    endcase
    pt.c = c[31:0];
    ps = shift_of(pt.p);
    span = 3 * ONE_Q + 2 * longint'(heat_cfg);
    off = longint'($urandom_range(0, 32'hffffffff)) % span - ONE_Q;
    if ($urandom_range(9) == 0) off = longint'($urandom_range(0, 3)) - 1;  // right on ps
    pt.h = 32'(ps + off);
    return pt;
  endfunction

  task automatic run_random(int n, bit with_pause);
    for (int i = 0; i < n; i++) point_q.push_back(random_point());
    if (with_pause) begin
      // Stop feeding mid-phase until every pending result is back.
      while (point_q.size() > n / 2) @(posedge clk_i);
      feed_hold = 1'b1;
      while (s_axis_tvalid || phase_exp_q.size() > 0) @(posedge clk_i);
      feed_hold = 1'b0;
    end
    settle();
  endtask

  initial begin
    longint lh;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed points under the reset register values.
    lh = longint'(heat_cfg);
    point_q.push_back(mk(0, 0, 0));                                   // solid olivine
    point_q.push_back(mk(-64'sd2147483648, -64'sd2147483648, 0));
    point_q.push_back(mk(64'sd2147483647, 64'sd2147483647, 24'hffffff));
    point_q.push_back(mk(64'sd2147483647, 0, 0));                     // melt, zero C
    point_q.push_back(mk(ONE_Q, 0, 0));                               // solid edge
    point_q.push_back(mk(ONE_Q + 1, 0, 0));
    point_q.push_back(mk(-ONE_Q, ONE_Q / 2, 0));                      // two solids
    point_q.push_back(mk(0, ONE_Q / 2, 0));                           // two-solid edge
    point_q.push_back(mk(ONE_Q / 10, ONE_Q / 2, 0));                  // eutectic
    point_q.push_back(mk(fx_mul(lh, ONE_Q / 2), ONE_Q / 2, 0));       // eutectic edge
    point_q.push_back(mk(ONE_Q / 2, ONE_Q / 2, 0));                   // super-eutectic
    point_q.push_back(mk(ONE_Q / 2 + lh, ONE_Q / 2, 0));              // super edge
    point_q.push_back(mk(ONE_Q / 2 + lh + 1, ONE_Q / 2, 0));          // all melt
    point_q.push_back(mk(2 * ONE_Q, ONE_Q / 2, 0));
    point_q.push_back(mk(ONE_Q / 5, 2 * ONE_Q, 0));                   // C above one
    point_q.push_back(mk(ONE_Q / 2, -ONE_Q, 0));                      // C below zero
    point_q.push_back(mk(ONE_Q / 2, ONE_Q / 2, 24'hffffff));          // large shift
    point_q.push_back(mk(ONE_Q * 17, ONE_Q / 2, 24'hffffff));
    point_q.push_back(mk(ONE_Q / 4, ONE_Q / 4, 24'd1000));
    point_q.push_back(mk(ONE_Q * 3 / 4, ONE_Q, 0));
    settle();
    run_random(230, 1'b1);

    // Zero slope and the smallest nonzero latent heat, fed without idling.
    write_reg(CFG_SLOPE, 32'd0);
    write_reg(CFG_HEAT, 32'd1);
    steady = 1'b1;
    run_random(200, 1'b0);
    steady = 1'b0;

    // Largest slope and a latent heat of 4.0.
    write_reg(CFG_SLOPE, 32'hffffffff);
    write_reg(CFG_HEAT, 32'd67108864);
    run_random(200, 1'b0);

    // Zero latent heat: every division by it faults.
    write_reg(CFG_SLOPE, $urandom);
    write_reg(CFG_HEAT, 32'd0);
    run_random(150, 1'b0);

    // Random register values.
    write_reg(CFG_SLOPE, $urandom);
    write_reg(CFG_HEAT, $urandom_range(1, 67108864));
    run_random(200, 1'b1);

    // Back to the defaults.
    write_reg(CFG_SLOPE, 32'd281474977);
    write_reg(CFG_HEAT, 32'd5033165);
    run_random(250, 1'b0);

    $display("sent %0d points, checked %0d results over six register settings",
             point_cnt, result_cnt);
    $display("regions 1..5 seen %0d/%0d/%0d/%0d/%0d times, %0d math faults",
             region_seen[1], region_seen[2], region_seen[3], region_seen[4],
             region_seen[5], fault_cnt);
    if (mismatch_cnt == 0 && phase_exp_q.size() == 0) begin
      $display("eutectic_phase_split_eval_tb OK");
    end else begin
      $display("eutectic_phase_split_eval_tb NOT OK");
    end
    $finish;
  end

endmodule
